>>> hw/rtl/hpt_pkg.sv
// shared constants and types for the homogeneous point transform
package hpt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = 32;
  localparam int COEFF_W     = 32;
  localparam int REG_W       = 2 * COEFF_W;
  localparam int NUM_REGS    = 8;
  localparam int NUM_ENTRIES = 2 * NUM_REGS;
  localparam int CFG_IDX_W   = 4;
  localparam int SUM_W       = COORD_WIDTH + COEFF_W + 2;
  localparam int MAG_W       = SUM_W;
  localparam int MAC_LAT     = 3;
  localparam int DIV_LAT     = COORD_WIDTH + 3;
  localparam int LAT         = MAC_LAT + DIV_LAT;

  typedef logic signed [COEFF_W-1:0]     coeff_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [REG_W-1:0]              cfg_reg_t;

  localparam cfg_reg_t REG_RESET [NUM_REGS] = '{
    cfg_reg_t'(65536), cfg_reg_t'(0), cfg_reg_t'(64'd281474976710656), cfg_reg_t'(0),
    cfg_reg_t'(0), cfg_reg_t'(65536), cfg_reg_t'(0), cfg_reg_t'(64'd281474976710656)
  };

endpackage

>>> hw/rtl/hpt_in_if.sv
// point request channel
interface hpt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_in;
  logic [31:0] y_in;
  logic [31:0] z_in;

  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink (input valid, x_in, y_in, z_in, output ready);
endinterface

>>> hw/rtl/hpt_out_if.sv
// transformed point result channel
interface hpt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic [31:0] z_out;
  logic        divide_by_zero;
  logic        saturated;

  modport source (output valid, x_out, y_out, z_out, divide_by_zero, saturated,
                  input ready);
  modport sink (input valid, x_out, y_out, z_out, divide_by_zero, saturated,
                output ready);
endinterface

>>> hw/rtl/hpt_row_mac.sv
// one matrix row: three products plus translation, three register stages
module hpt_row_mac import hpt_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  coord_t x,
  input  coord_t y,
  input  coord_t z,
  input  coeff_t cx,
  input  coeff_t cy,
  input  coeff_t cz,
  input  coeff_t ct,
  output sum_t   sum
);

  logic signed [COORD_WIDTH+COEFF_W-1:0] p0, p1, p2;
  sum_t tt, s01, s2t;

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= x * cx;
      p1  <= y * cy;
      p2  <= z * cz;
      tt  <= sum_t'(ct) <<< FRAC_BITS;
      s01 <= sum_t'(p0) + sum_t'(p1);
      s2t <= sum_t'(p2) + tt;
      sum <= s01 + s2t;
    end
  end

endmodule

>>> hw/rtl/hpt_divider.sv
// pipelined signed divider, one quotient bit per stage, with saturation
module hpt_divider import hpt_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  sum_t                   num,
  input  sum_t                   den,
  output logic [COORD_WIDTH-1:0] quo,
  output logic                   sat,
  output logic                   zero
);

  localparam int SH = COORD_WIDTH - FRAC_BITS;

  logic [MAG_W-1:0]       nmag, dmag;
  logic                   neg1, zero1;
  logic [MAG_W-1:0]       rem  [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] lo   [COORD_WIDTH+1];
  logic [MAG_W-1:0]       d    [COORD_WIDTH+1];
  logic                   neg  [COORD_WIDTH+1];
  logic                   big  [COORD_WIDTH+1];
  logic                   zr   [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] limit, qmag;
  logic                   over;

  // magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      nmag  <= num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      dmag  <= den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
      neg1  <= num[SUM_W-1] ^ den[SUM_W-1];
      zero1 <= (den == '0);
    end
  end

  // overflow check and remainder setup
  always_ff @(posedge clk) begin
    if (en) begin
      big[0]  <= {{SH{1'b0}}, nmag} >= {dmag, {SH{1'b0}}};
      rem[0]  <= MAG_W'(nmag >> SH);
      lo[0]   <= {nmag[SH-1:0], {FRAC_BITS{1'b0}}};
      d[0]    <= dmag;
      neg[0]  <= neg1;
      zr[0]   <= zero1;
    end
  end

  for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_step
    logic [MAG_W:0] t;
    logic           ge;
    assign t  = {rem[i], lo[i][COORD_WIDTH-1]};
    assign ge = t >= {1'b0, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? MAG_W'(t - {1'b0, d[i]}) : MAG_W'(t);
        lo[i+1]  <= {lo[i][COORD_WIDTH-2:0], ge};
        d[i+1]   <= d[i];
        neg[i+1] <= neg[i];
        big[i+1] <= big[i];
        zr[i+1]  <= zr[i];
      end
    end
  end

  always_comb begin
    limit = neg[COORD_WIDTH] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                             : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    over  = big[COORD_WIDTH] || (lo[COORD_WIDTH] > limit);
    qmag  = over ? limit : lo[COORD_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo  <= zr[COORD_WIDTH] ? '0 : (neg[COORD_WIDTH] ? -qmag : qmag);
      sat  <= !zr[COORD_WIDTH] && over;
      zero <= zr[COORD_WIDTH];
    end
  end

endmodule

>>> hw/rtl/homogeneous_point_transform.sv
// homogeneous 4x4 point transform with perspective divide
// pipeline: 3 multiply/add stages followed by 35 divide stages
// throughput: one point per cycle while the result is not stalled; the divider retires one quotient bit per stage
// a stalled result holds the whole pipeline in place
// reset clears all valid bits and loads the identity matrix
module homogeneous_point_transform import hpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  hpt_in_if.sink               point,
  hpt_out_if.source            result
);

  cfg_reg_t               coeff [NUM_REGS];
  coeff_t                 entry [NUM_ENTRIES];
  logic [LAT-1:0]         vld;
  logic                   en;
  coord_t                 px, py, pz;
  sum_t                   row [4];
  logic [COORD_WIDTH-1:0] q [3];
  logic                   sat [3];
  logic                   zero [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= REG_RESET;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coeff[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
    end
  end

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_entry
    assign entry[k] = (k % 2 == 1) ? coeff_t'(coeff[k/2][REG_W-1:COEFF_W])
                                   : coeff_t'(coeff[k/2][COEFF_W-1:0]);
  end

  assign en          = !vld[LAT-1] || result.ready;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], point.valid};
    end
  end

  assign px = coord_t'(point.x_in[COORD_WIDTH-1:0]);
  assign py = coord_t'(point.y_in[COORD_WIDTH-1:0]);
  assign pz = coord_t'(point.z_in[COORD_WIDTH-1:0]);

  for (genvar j = 0; j < 4; j++) begin : g_row
    hpt_row_mac u_mac (
      .clk (clk),
      .en  (en),
      .x   (px),
      .y   (py),
      .z   (pz),
      .cx  (entry[j]),
      .cy  (entry[4+j]),
      .cz  (entry[8+j]),
      .ct  (entry[12+j]),
      .sum (row[j])
    );
  end

  for (genvar j = 0; j < 3; j++) begin : g_div
    hpt_divider u_div (
      .clk  (clk),
      .en   (en),
      .num  (row[j]),
      .den  (row[3]),
      .quo  (q[j]),
      .sat  (sat[j]),
      .zero (zero[j])
    );
  end

  assign result.valid          = vld[LAT-1];
  assign result.x_out          = OUT_W'($signed(q[0]));
  assign result.y_out          = OUT_W'($signed(q[1]));
  assign result.z_out          = OUT_W'($signed(q[2]));
  assign result.divide_by_zero = zero[0];
  assign result.saturated      = sat[0] || sat[1] || sat[2];

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready) |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> point.ready)
    else $error("input stalled with no result pending");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.divide_by_zero) |->
      (!result.saturated && result.x_out == '0 && result.y_out == '0 && result.z_out == '0))
    else $error("divide by zero result not cleared");

endmodule
